/* sv/lifo_stack_positional_edit_defines.svh */
// Assertion macros for the port-level checker of the positional-edit LIFO stack.
`ifndef LIFO_STACK_POSITIONAL_EDIT_DEFINES_SVH
`define LIFO_STACK_POSITIONAL_EDIT_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled while rst is high.
`define LSPE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst is high.
`define LSPE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* sv/lifo_pe_pkg.sv */
// Package with the types, codes and defaults of the positional-edit LIFO stack.
package lifo_pe_pkg;

  // Default sizes for the top-level parameters.
  localparam int DEPTH_DEF      = 16;
  localparam int WORD_WIDTH_DEF = 32;

  // Fixed port field widths.
  localparam int FUNC_W   = 3;
  localparam int VALUE_W  = 32;
  localparam int POS_W    = 5;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  // Operation codes; codes five to seven are no-ops.
  typedef enum logic [FUNC_W-1:0] {
    FUNC_PUSH   = 3'd0,
    FUNC_POP    = 3'd1,
    FUNC_DELETE = 3'd2,
    FUNC_INSERT = 3'd3,
    FUNC_CLEAR  = 3'd4
  } func_t;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_BADPOS = 2'd2,
    ST_FULL   = 2'd3
  } status_t;

  // One request beat as held in the input register.
  typedef struct packed {
    func_t              func;
    logic [VALUE_W-1:0] value;
    logic [POS_W-1:0]   position;
  } req_t;

  // One result beat as held in the output register.
  typedef struct packed {
    logic [VALUE_W-1:0] popped_value;
    status_t            status;
    logic [COUNT_W-1:0] count;
    logic               is_empty;
  } rsp_t;

endpackage

/* sv/lifo_pe_core.sv */
// Stack storage, fill count and the single-pass operation logic of the LIFO stack.
module lifo_pe_core #(
  parameter int DEPTH      = lifo_pe_pkg::DEPTH_DEF,
  parameter int WORD_WIDTH = lifo_pe_pkg::WORD_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              fire,
  input  lifo_pe_pkg::req_t req,
  output lifo_pe_pkg::rsp_t rsp
);

  localparam int CW   = $clog2(DEPTH + 1);
  localparam int AW   = $clog2(DEPTH);
  localparam int CMPW = (CW > lifo_pe_pkg::POS_W) ? CW : lifo_pe_pkg::POS_W;

  // Entry zero is the bottom of the stack.
  logic [WORD_WIDTH-1:0] entries      [DEPTH];
  logic [WORD_WIDTH-1:0] entries_next [DEPTH];
  logic [CW-1:0]         fill_count;
  logic [CW-1:0]         fill_count_next;

  logic [CW-1:0]         pos_c;
  logic [CW-1:0]         del_idx;
  logic [CW-1:0]         ins_idx;
  logic [CW-1:0]         rd_idx;
  logic [WORD_WIDTH-1:0] rd_word;
  logic [WORD_WIDTH-1:0] val_w;
  logic                  pos_ok;
  logic                  full;
  logic                  empty;
  logic                  do_push;
  logic                  do_del;
  logic                  do_ins;
  logic                  take_word;
  lifo_pe_pkg::status_t  status;

  // Position arithmetic; a position is used only after it is known to be in range.
  assign pos_ok  = (req.position != '0) && (CMPW'(req.position) <= CMPW'(fill_count));
  assign pos_c   = CW'(req.position);
  assign del_idx = fill_count - pos_c;
  assign ins_idx = del_idx + CW'(1);
  assign full    = (fill_count == CW'(DEPTH));
  assign empty   = (fill_count == '0);
  assign val_w   = WORD_WIDTH'($signed(req.value));

  // The pop reads the top entry, the delete reads the entry at the position.
  assign rd_idx  = (req.func == lifo_pe_pkg::FUNC_POP) ? (fill_count - CW'(1)) : del_idx;
  assign rd_word = entries[rd_idx[AW-1:0]];

  // Operation decode, status and new fill count.
  always_comb begin
    do_push         = 1'b0;
    do_del          = 1'b0;
    do_ins          = 1'b0;
    take_word       = 1'b0;
    status          = lifo_pe_pkg::ST_OK;
    fill_count_next = fill_count;
    unique case (req.func)
      lifo_pe_pkg::FUNC_PUSH: begin
        if (full) begin
          status = lifo_pe_pkg::ST_FULL;
        end else begin
          do_push         = 1'b1;
          fill_count_next = fill_count + CW'(1);
        end
      end
      lifo_pe_pkg::FUNC_POP: begin
        if (empty) begin
          status = lifo_pe_pkg::ST_EMPTY;
        end else begin
          take_word       = 1'b1;
          fill_count_next = fill_count - CW'(1);
        end
      end
      lifo_pe_pkg::FUNC_DELETE: begin
        if (!pos_ok) begin
          status = lifo_pe_pkg::ST_BADPOS;
        end else begin
          do_del          = 1'b1;
          take_word       = 1'b1;
          fill_count_next = fill_count - CW'(1);
        end
      end
      lifo_pe_pkg::FUNC_INSERT: begin
        if (!pos_ok) begin
          status = lifo_pe_pkg::ST_BADPOS;
        end else if (full) begin
          status = lifo_pe_pkg::ST_FULL;
        end else begin
          do_ins          = 1'b1;
          fill_count_next = fill_count + CW'(1);
        end
      end
      lifo_pe_pkg::FUNC_CLEAR: begin
        fill_count_next = '0;
      end
      default: begin
      end
    endcase
  end

  // Per-entry next value: each entry keeps its word, takes a neighbor or loads the new word.
  for (genvar g = 0; g < DEPTH; g++) begin : g_entry
    logic [WORD_WIDTH-1:0] above;
    logic [WORD_WIDTH-1:0] below;

    if (g < DEPTH - 1) begin : g_above
      assign above = entries[g+1];
    end else begin : g_top
      assign above = '0;
    end

    if (g > 0) begin : g_below
      assign below = entries[g-1];
    end else begin : g_bottom
      assign below = '0;
    end

    always_comb begin
      entries_next[g] = entries[g];
      if (do_push && (CW'(g) == fill_count)) begin
        entries_next[g] = val_w;
      end else if (do_del && (CW'(g) >= del_idx) && ((CW'(g) + CW'(1)) < fill_count)) begin
        entries_next[g] = above;
      end else if (do_ins && (CW'(g) == ins_idx)) begin
        entries_next[g] = val_w;
      end else if (do_ins && (CW'(g) > ins_idx) && (CW'(g) <= fill_count)) begin
        entries_next[g] = below;
      end
    end
  end

  // Storage words hold no reset; only written entries are ever read.
  always_ff @(posedge clk) begin
    if (fire) begin
      for (int i = 0; i < DEPTH; i++) begin
        entries[i] <= entries_next[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
    end else if (fire) begin
      fill_count <= fill_count_next;
    end
  end

  // Result of the request, sign extended from the stored word width.
  always_comb begin
    rsp.popped_value = take_word ? lifo_pe_pkg::VALUE_W'($signed(rd_word)) : '0;
    rsp.status       = status;
    rsp.count        = lifo_pe_pkg::COUNT_W'(fill_count_next);
    rsp.is_empty     = (fill_count_next == '0);
  end

endmodule

/* sv/lifo_stack_positional_edit.sv */
// Top level of the positional-edit LIFO stack: request register, stack core, result register.
//
// A bounded LIFO stack of signed words that takes push, pop, delete at a position,
// insert at a position and clear requests and answers each with one result beat that
// carries the removed word, a status code and the count after the request. One
// request is accepted every clock cycle when the result side keeps taking beats. An
// accepted request waits in the request register until it can move on; the core then
// works out its result and the result register captures the beat, which stays on the
// result ports until the result side takes it. Every shift, load and read of one
// request is done combinationally by the per-entry multiplexers between those two
// registers, and the entry array is written as the request moves on. The request side
// keeps accepting while a finished result waits, as long as the request register is
// free or moves on in the same cycle.
module lifo_stack_positional_edit #(
  parameter int DEPTH      = lifo_pe_pkg::DEPTH_DEF,
  parameter int WORD_WIDTH = lifo_pe_pkg::WORD_WIDTH_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    req_valid,
  output logic                                    req_ready,
  input  logic [lifo_pe_pkg::FUNC_W-1:0]          func,
  input  logic signed [lifo_pe_pkg::VALUE_W-1:0]  value,
  input  logic [lifo_pe_pkg::POS_W-1:0]           position,
  output logic                                    rsp_valid,
  input  logic                                    rsp_ready,
  output logic signed [lifo_pe_pkg::VALUE_W-1:0]  popped_value,
  output logic [lifo_pe_pkg::STATUS_W-1:0]        status,
  output logic [lifo_pe_pkg::COUNT_W-1:0]         count,
  output logic                                    is_empty
);

  lifo_pe_pkg::req_t req_q;
  logic              req_q_valid;
  lifo_pe_pkg::rsp_t rsp_d;
  lifo_pe_pkg::rsp_t rsp_q;
  logic              advance;

  // The held request moves on when the result register is free or drains this cycle.
  assign advance   = req_q_valid && (!rsp_valid || rsp_ready);
  assign req_ready = !req_q_valid || advance;

  // Request register.
  always_ff @(posedge clk) begin
    if (rst) begin
      req_q_valid <= 1'b0;
    end else if (req_ready) begin
      req_q_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      req_q.func     <= lifo_pe_pkg::func_t'(func);
      req_q.value    <= value;
      req_q.position <= position;
    end
  end

  lifo_pe_core #(
    .DEPTH      (DEPTH),
    .WORD_WIDTH (WORD_WIDTH)
  ) u_core (
    .clk  (clk),
    .rst  (rst),
    .fire (advance),
    .req  (req_q),
    .rsp  (rsp_d)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (advance) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rsp_q <= rsp_d;
    end
  end

  assign popped_value = rsp_q.popped_value;
  assign status       = rsp_q.status;
  assign count        = rsp_q.count;
  assign is_empty     = rsp_q.is_empty;

endmodule

/* sv/lifo_pe_checker.sv */
// Port-level checker for the positional-edit LIFO stack and its bind to the top level.
`include "lifo_stack_positional_edit_defines.svh"

module lifo_pe_checker #(
  parameter int DEPTH = lifo_pe_pkg::DEPTH_DEF
) (
  input logic                                clk,
  input logic                                rst,
  input logic                                rsp_valid,
  input logic                                rsp_ready,
  input logic [lifo_pe_pkg::VALUE_W-1:0]     popped_value,
  input logic [lifo_pe_pkg::STATUS_W-1:0]    status,
  input logic [lifo_pe_pkg::COUNT_W-1:0]     count,
  input logic                                is_empty
);

  // A stalled result beat stays on the port unchanged.
  `LSPE_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(popped_value) && $stable(status) && $stable(count) && $stable(is_empty), "result beat changed while stalled")

  // The empty flag follows the reported count.
  `LSPE_ASSERT_NOW(a_empty_flag, rsp_valid, is_empty == (count == '0), "is_empty disagrees with count")

  // A pop on an empty stack removes nothing and leaves the stack empty.
  `LSPE_ASSERT_NOW(a_empty_pop, rsp_valid && (status == lifo_pe_pkg::ST_EMPTY), (popped_value == '0) && (count == '0) && is_empty, "empty status with a word or entries")

  // A refused push or insert reports a full stack.
  `LSPE_ASSERT_NOW(a_full_count, rsp_valid && (status == lifo_pe_pkg::ST_FULL), (count == lifo_pe_pkg::COUNT_W'(DEPTH)) && (popped_value == '0), "full status without a full count")

endmodule

bind lifo_stack_positional_edit lifo_pe_checker #(
  .DEPTH (DEPTH)
) u_lifo_pe_checker (
  .clk          (clk),
  .rst          (rst),
  .rsp_valid    (rsp_valid),
  .rsp_ready    (rsp_ready),
  .popped_value (popped_value),
  .status       (status),
  .count        (count),
  .is_empty     (is_empty)
);
